// ===== rtl/core/srx_pkg.sv =====
// types and constants shared by the segment/rectangle intersection pipeline
`timescale 1ns / 1ps
package srx_pkg;

  localparam int COORD_BITS = 32;
  localparam int EXT_BITS   = COORD_BITS + 1;
  localparam int DIFF_BITS  = COORD_BITS + 2;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int REM_BITS   = SUM_BITS + 1;
  localparam int DIV_STEPS  = DIFF_BITS;
  localparam int LANE_DEPTH = DIV_STEPS + 6;
  localparam int NUM_LANES  = 4;

  localparam logic OP_SEGMENT = 1'b0;
  localparam logic OP_RECT    = 1'b1;

  typedef struct packed {
    logic                         op;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] other_x0;
    logic signed [COORD_BITS-1:0] other_y0;
    logic signed [COORD_BITS-1:0] other_x1;
    logic signed [COORD_BITS-1:0] other_y1;
  } srx_in_t;

  typedef struct packed {
    logic                         hit;
    logic                         whole_inside;
    logic signed [COORD_BITS-1:0] hit_x;
    logic signed [COORD_BITS-1:0] hit_y;
  } srx_out_t;

  typedef struct packed {
    logic signed [DIFF_BITS-1:0]  s1x;
    logic signed [DIFF_BITS-1:0]  s1y;
    logic signed [DIFF_BITS-1:0]  s2x;
    logic signed [DIFF_BITS-1:0]  s2y;
    logic signed [DIFF_BITS-1:0]  dx;
    logic signed [DIFF_BITS-1:0]  dy;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
  } srx_lane_in_t;

  typedef struct packed {
    logic                         hit;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic [SUM_BITS-1:0]          dsq;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
  } srx_lane_out_t;

  typedef struct packed {
    logic [REM_BITS-1:0]  rem;
    logic [DIFF_BITS-1:0] quo;
    logic [DIFF_BITS-1:0] mul;
  } srx_div_t;

  typedef struct packed {
    logic                         ok;
    logic                         negx;
    logic                         negy;
    logic [SUM_BITS-1:0]          num;
    logic [SUM_BITS-1:0]          den;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
  } srx_dside_t;

  typedef struct packed {
    logic op;
    logic ends_in;
  } srx_tag_t;

endpackage

// ===== rtl/core/segment_rect_intersection.sv =====
// top level: segment against segment or against an axis-aligned rectangle
//
// usage
//   in channel: in_data carries one query (op, segment, second shape); a
//   transfer happens when in_valid is high and in_stall is low
//   out channel: out_data carries hit, whole_inside and the point; a transfer
//   happens when out_valid is high and out_stall is low
//   one result per query, in query order
// timing
//   fully pipelined, one query per cycle while in_stall is low; the depth
//   from input transfer to out_valid is set mainly by the long-division chain
//   that scales the crossing parameter, one bit per stage
// reset
//   rst_n low clears every valid bit; payload registers are not reset
// stall
//   a stalled result holds in the output register; the pipeline keeps
//   taking queries until its last stage is full, then in_stall rises
//   nothing is dropped or repeated
`timescale 1ns / 1ps
module segment_rect_intersection import srx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  srx_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output srx_out_t out_data
);

  // pipe stages: entry, lane stages, pair compare
  localparam int NP = LANE_DEPTH + 2;

  function automatic srx_lane_out_t pick(srx_lane_out_t a, srx_lane_out_t b);
    return (a.hit && (!b.hit || a.dsq <= b.dsq)) ? a : b;
  endfunction

  logic [NP-1:0] v_r;
  logic          pipe_en;
  logic          out_valid_r;
  srx_out_t      out_data_r;

  // pipe moves unless its last stage is full and the output is held
  assign pipe_en  = !v_r[NP-1] || !out_valid_r || !out_stall;
  assign in_stall = !pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (pipe_en) begin
      v_r <= {v_r[NP-2:0], in_valid};
    end
  end

  // entry stage: rectangle edges, differences, inside test
  logic signed [EXT_BITS-1:0] sx, sy, ex, ey, ax, ay, bx, by, rgt, bot;
  logic signed [EXT_BITS-1:0] o0x [NUM_LANES];
  logic signed [EXT_BITS-1:0] o0y [NUM_LANES];
  logic signed [EXT_BITS-1:0] o1x [NUM_LANES];
  logic signed [EXT_BITS-1:0] o1y [NUM_LANES];
  logic                       ends_in;
  logic                       is_rect;

  assign sx  = EXT_BITS'(in_data.start_x);
  assign sy  = EXT_BITS'(in_data.start_y);
  assign ex  = EXT_BITS'(in_data.end_x);
  assign ey  = EXT_BITS'(in_data.end_y);
  assign ax  = EXT_BITS'(in_data.other_x0);
  assign ay  = EXT_BITS'(in_data.other_y0);
  assign bx  = EXT_BITS'(in_data.other_x1);
  assign by  = EXT_BITS'(in_data.other_y1);
  // right and bottom edges without wrap
  assign rgt = ax + bx;
  assign bot = ay + by;
  assign is_rect = (in_data.op == OP_RECT);

  assign ends_in = (ax <= sx) && (sx <= rgt) && (ay <= sy) && (sy <= bot) &&
                   (ax <= ex) && (ex <= rgt) && (ay <= ey) && (ey <= bot);

  always_comb begin
    // lane 0: other segment, or the top edge
    o0x[0] = ax;
    o0y[0] = ay;
    o1x[0] = is_rect ? rgt : bx;
    o1y[0] = is_rect ? ay : by;
    // bottom edge
    o0x[1] = ax;
    o0y[1] = bot;
    o1x[1] = rgt;
    o1y[1] = bot;
    // left edge
    o0x[2] = ax;
    o0y[2] = ay;
    o1x[2] = ax;
    o1y[2] = bot;
    // right edge
    o0x[3] = rgt;
    o0y[3] = ay;
    o1x[3] = rgt;
    o1y[3] = bot;
  end

  srx_lane_in_t  a_lane_r [NUM_LANES];
  srx_lane_out_t lane_out [NUM_LANES];
  srx_tag_t      tag_r    [LANE_DEPTH+1];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      tag_r[0].op      <= in_data.op;
      tag_r[0].ends_in <= is_rect && ends_in;
    end
  end

  for (genvar i = 1; i <= LANE_DEPTH; i++) begin : g_tag
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        a_lane_r[k].s1x <= DIFF_BITS'(ex) - DIFF_BITS'(sx);
        a_lane_r[k].s1y <= DIFF_BITS'(ey) - DIFF_BITS'(sy);
        a_lane_r[k].s2x <= DIFF_BITS'(o1x[k]) - DIFF_BITS'(o0x[k]);
        a_lane_r[k].s2y <= DIFF_BITS'(o1y[k]) - DIFF_BITS'(o0y[k]);
        a_lane_r[k].dx  <= DIFF_BITS'(sx) - DIFF_BITS'(o0x[k]);
        a_lane_r[k].dy  <= DIFF_BITS'(sy) - DIFF_BITS'(o0y[k]);
        a_lane_r[k].sx  <= in_data.start_x;
        a_lane_r[k].sy  <= in_data.start_y;
      end
    end

    srx_lane u_lane (
      .clk      (clk),
      .en       (pipe_en),
      .lane_in  (a_lane_r[k]),
      .lane_out (lane_out[k])
    );
  end

  // pair compare; segment mode and whole-inside folded in here
  srx_tag_t      lt;
  srx_lane_out_t p_nxt, q_nxt, no_hit, at_start;
  srx_lane_out_t h_p_r, h_q_r;
  logic          h_inside_r;

  assign lt = tag_r[LANE_DEPTH];

  always_comb begin
    no_hit       = lane_out[0];
    no_hit.hit   = 1'b0;
    at_start     = lane_out[0];
    at_start.hit = 1'b1;
    at_start.px  = lane_out[0].sx;
    at_start.py  = lane_out[0].sy;
    if (lt.op == OP_SEGMENT) begin
      p_nxt = lane_out[0];
      q_nxt = no_hit;
    end else if (lt.ends_in) begin
      p_nxt = at_start;
      q_nxt = no_hit;
    end else begin
      p_nxt = pick(lane_out[0], lane_out[1]);
      q_nxt = pick(lane_out[2], lane_out[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      h_p_r      <= p_nxt;
      h_q_r      <= q_nxt;
      h_inside_r <= lt.ends_in;
    end
  end

  // final pick into the output register
  srx_lane_out_t win;

  assign win = pick(h_p_r, h_q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= v_r[NP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_data_r.hit          <= win.hit;
      out_data_r.whole_inside <= h_inside_r;
      out_data_r.hit_x        <= win.hit ? win.px : '0;
      out_data_r.hit_y        <= win.hit ? win.py : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_inside_hit : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.whole_inside || out_data_r.hit))
    else $error("whole_inside without hit");

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.hit) |-> (out_data_r.hit_x == '0 && out_data_r.hit_y == '0))
    else $error("miss with nonzero point");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_r[NP-1] && out_valid_r && out_stall))
    else $error("input held without a full pipe");

  a_hold_last : assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && !in_valid) |=> v_r[NP-1])
    else $error("last stage lost while held");

endmodule

// ===== rtl/core/srx_lane.sv =====
// one crossing lane: products, normalize, scaled division, point and distance
`timescale 1ns / 1ps
module srx_lane import srx_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  srx_lane_in_t  lane_in,
  output srx_lane_out_t lane_out
);

  // one long-division step, up to two subtracts done in parallel
  function automatic srx_div_t div_step(srx_div_t s, logic [SUM_BITS-1:0] num,
                                        logic [SUM_BITS-1:0] den);
    logic [REM_BITS-1:0] r2;
    logic [REM_BITS-1:0] d1;
    logic [REM_BITS-1:0] d2;
    logic [1:0]          c;
    srx_div_t            o;
    r2 = {s.rem[REM_BITS-2:0], 1'b0} + (s.mul[DIFF_BITS-1] ? REM_BITS'(num) : '0);
    d1 = REM_BITS'(den);
    d2 = {den, 1'b0};
    if (r2 >= d2) begin
      o.rem = r2 - d2;
      c = 2'd2;
    end else if (r2 >= d1) begin
      o.rem = r2 - d1;
      c = 2'd1;
    end else begin
      o.rem = r2;
      c = 2'd0;
    end
    o.quo = {s.quo[DIFF_BITS-2:0], 1'b0} + DIFF_BITS'(c);
    o.mul = {s.mul[DIFF_BITS-2:0], 1'b0};
    return o;
  endfunction

  // products
  logic signed [PROD_BITS-1:0] b_da_r, b_db_r, b_sa_r, b_sb_r, b_ta_r, b_tb_r;
  logic signed [DIFF_BITS-1:0] b_s1x_r, b_s1y_r;
  logic signed [COORD_BITS-1:0] b_sx_r, b_sy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_da_r  <= $signed(lane_in.s1x) * $signed(lane_in.s2y);
      b_db_r  <= $signed(lane_in.s2x) * $signed(lane_in.s1y);
      b_sa_r  <= $signed(lane_in.s1x) * $signed(lane_in.dy);
      b_sb_r  <= $signed(lane_in.s1y) * $signed(lane_in.dx);
      b_ta_r  <= $signed(lane_in.s2x) * $signed(lane_in.dy);
      b_tb_r  <= $signed(lane_in.s2y) * $signed(lane_in.dx);
      b_s1x_r <= lane_in.s1x;
      b_s1y_r <= lane_in.s1y;
      b_sx_r  <= lane_in.sx;
      b_sy_r  <= lane_in.sy;
    end
  end

  // cross products
  logic signed [SUM_BITS-1:0] c_den_r, c_sn_r, c_tn_r;
  logic signed [DIFF_BITS-1:0] c_s1x_r, c_s1y_r;
  logic signed [COORD_BITS-1:0] c_sx_r, c_sy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_den_r <= SUM_BITS'(b_da_r) - SUM_BITS'(b_db_r);
      c_sn_r  <= SUM_BITS'(b_sa_r) - SUM_BITS'(b_sb_r);
      c_tn_r  <= SUM_BITS'(b_ta_r) - SUM_BITS'(b_tb_r);
      c_s1x_r <= b_s1x_r;
      c_s1y_r <= b_s1y_r;
      c_sx_r  <= b_sx_r;
      c_sy_r  <= b_sy_r;
    end
  end

  // sign normalize and range test
  logic                        neg;
  logic signed [SUM_BITS-1:0]  den_n, sn_n, tn_n;
  logic                        ok;
  logic [DIFF_BITS-1:0]        mx, my;

  assign neg   = c_den_r[SUM_BITS-1];
  assign den_n = neg ? -c_den_r : c_den_r;
  assign sn_n  = neg ? -c_sn_r : c_sn_r;
  assign tn_n  = neg ? -c_tn_r : c_tn_r;
  assign ok    = (den_n != '0) && !sn_n[SUM_BITS-1] && (sn_n <= den_n) &&
                 !tn_n[SUM_BITS-1] && (tn_n <= den_n);
  assign mx    = c_s1x_r[DIFF_BITS-1] ? DIFF_BITS'(-c_s1x_r) : DIFF_BITS'(c_s1x_r);
  assign my    = c_s1y_r[DIFF_BITS-1] ? DIFF_BITS'(-c_s1y_r) : DIFF_BITS'(c_s1y_r);

  srx_div_t   d_x_r, d_y_r;
  srx_dside_t d_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_x_r         <= '{rem: '0, quo: '0, mul: mx};
      d_y_r         <= '{rem: '0, quo: '0, mul: my};
      d_side_r.ok   <= ok;
      d_side_r.negx <= c_s1x_r[DIFF_BITS-1];
      d_side_r.negy <= c_s1y_r[DIFF_BITS-1];
      d_side_r.num  <= SUM_BITS'(tn_n);
      d_side_r.den  <= SUM_BITS'(den_n);
      d_side_r.sx   <= c_sx_r;
      d_side_r.sy   <= c_sy_r;
    end
  end

  // scaled division, one multiplier bit per stage
  srx_div_t   dvx_r  [DIV_STEPS];
  srx_div_t   dvy_r  [DIV_STEPS];
  srx_dside_t dside_r[DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    srx_div_t   x_in, y_in;
    srx_dside_t s_in;
    if (j == 0) begin : g_first
      assign x_in = d_x_r;
      assign y_in = d_y_r;
      assign s_in = d_side_r;
    end else begin : g_next
      assign x_in = dvx_r[j-1];
      assign y_in = dvy_r[j-1];
      assign s_in = dside_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dvx_r[j]   <= div_step(x_in, s_in.num, s_in.den);
        dvy_r[j]   <= div_step(y_in, s_in.num, s_in.den);
        dside_r[j] <= s_in;
      end
    end
  end

  // crossing point
  srx_dside_t           last_side;
  logic [DIFF_BITS-1:0] qx, qy, offx, offy;

  assign last_side = dside_r[DIV_STEPS-1];
  assign qx   = dvx_r[DIV_STEPS-1].quo;
  assign qy   = dvy_r[DIV_STEPS-1].quo;
  assign offx = last_side.negx ? (DIFF_BITS'(0) - qx) : qx;
  assign offy = last_side.negy ? (DIFF_BITS'(0) - qy) : qy;

  logic                         e_ok_r, f_ok_r, g_ok_r;
  logic signed [COORD_BITS-1:0] e_px_r, e_py_r, f_px_r, f_py_r, g_px_r, g_py_r;
  logic signed [COORD_BITS-1:0] e_sx_r, e_sy_r, f_sx_r, f_sy_r, g_sx_r, g_sy_r;
  logic [DIFF_BITS-1:0]         e_qx_r, e_qy_r;
  logic [PROD_BITS-1:0]         f_sqx_r, f_sqy_r;
  logic [SUM_BITS-1:0]          g_dist_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e_ok_r   <= last_side.ok;
      e_px_r   <= last_side.sx + $signed(offx[COORD_BITS-1:0]);
      e_py_r   <= last_side.sy + $signed(offy[COORD_BITS-1:0]);
      e_sx_r   <= last_side.sx;
      e_sy_r   <= last_side.sy;
      e_qx_r   <= qx;
      e_qy_r   <= qy;
      // squared distance from start
      f_ok_r   <= e_ok_r;
      f_px_r   <= e_px_r;
      f_py_r   <= e_py_r;
      f_sx_r   <= e_sx_r;
      f_sy_r   <= e_sy_r;
      f_sqx_r  <= e_qx_r * e_qx_r;
      f_sqy_r  <= e_qy_r * e_qy_r;
      g_ok_r   <= f_ok_r;
      g_px_r   <= f_px_r;
      g_py_r   <= f_py_r;
      g_sx_r   <= f_sx_r;
      g_sy_r   <= f_sy_r;
      g_dist_r <= SUM_BITS'(f_sqx_r) + SUM_BITS'(f_sqy_r);
    end
  end

  assign lane_out = '{hit: g_ok_r, px: g_px_r, py: g_py_r, dsq: g_dist_r,
                      sx: g_sx_r, sy: g_sy_r};

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the segment/rectangle intersection pipeline
`timescale 1ns / 1ps
module tb_top;
  import srx_pkg::*;

  // wide signed type, enough for the exact crossing products and the scaled quotient
  typedef logic signed [127:0] wide_t;

  localparam int LATENCY   = COORD_BITS + 10;
  localparam int MAX_CYC   = 400000;
  localparam int HOLD_CYC  = 300;
  localparam logic signed [COORD_BITS-1:0] ONE = 32'sh0001_0000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  srx_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  srx_out_t out_data;

  srx_in_t  query_q[$];     // queries waiting to be driven
  srx_out_t result_q[$];    // predicted results, oldest first
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       err_cnt = 0;
  int       cyc = 0;
  bit       hold_req = 1'b0;
  bit       hold_ack = 1'b0;
  int       hold_left = 0;

  segment_rect_intersection uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // exact crossing of segment p0-p1 with segment p2-p3; offset from p0 truncated toward zero
  function automatic bit seg_cross(input wide_t p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y,
                                   output wide_t hx, output wide_t hy);
    wide_t s1x, s1y, s2x, s2y, dx, dy, den, sn, tn, qx, qy;
    s1x = p1x - p0x;  s1y = p1y - p0y;
    s2x = p3x - p2x;  s2y = p3y - p2y;
    dx  = p0x - p2x;  dy  = p0y - p2y;
    den = s1x * s2y - s2x * s1y;
    sn  = s1x * dy - s1y * dx;
    tn  = s2x * dy - s2y * dx;
    hx = '0;
    hy = '0;
    // parallel or collinear: never a hit
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den;
      sn  = -sn;
      tn  = -tn;
    end
    if (sn < 0 || sn > den || tn < 0 || tn > den) return 1'b0;
    qx = ((s1x < 0 ? -s1x : s1x) * tn) / den;
    qy = ((s1y < 0 ? -s1y : s1y) * tn) / den;
    hx = p0x + (s1x < 0 ? -qx : qx);
    hy = p0y + (s1y < 0 ? -qy : qy);
    return 1'b1;
  endfunction

  function automatic srx_out_t predict_hit(input srx_in_t q);
    srx_out_t r;
    wide_t sx, sy, ex, ey, ax, ay, bx, by, rgt, bot, px, py, dsq, best;
    wide_t edge_c[4][4];
    bit found;
    sx = q.start_x;   sy = q.start_y;   ex = q.end_x;     ey = q.end_y;
    ax = q.other_x0;  ay = q.other_y0;  bx = q.other_x1;  by = q.other_y1;
    r = '0;
    best = '0;
    if (q.op == OP_SEGMENT) begin
      found = seg_cross(sx, sy, ex, ey, ax, ay, bx, by, px, py);
      if (found) begin
        r.hit = 1'b1;
        r.hit_x = px[COORD_BITS-1:0];
        r.hit_y = py[COORD_BITS-1:0];
      end
    end else begin
      // right and bottom edges computed without wrap
      rgt = ax + bx;
      bot = ay + by;
      if (ax <= sx && sx <= rgt && ay <= sy && sy <= bot &&
          ax <= ex && ex <= rgt && ay <= ey && ey <= bot) begin
        r.hit = 1'b1;
        r.whole_inside = 1'b1;
        r.hit_x = q.start_x;
        r.hit_y = q.start_y;
      end else begin
        // top, bottom, left, right; strict compare keeps the earlier edge on ties
        edge_c = '{'{ax, ay, rgt, ay}, '{ax, bot, rgt, bot},
                   '{ax, ay, ax, bot}, '{rgt, ay, rgt, bot}};
        for (int k = 0; k < 4; k++) begin
          if (seg_cross(sx, sy, ex, ey, edge_c[k][0], edge_c[k][1],
                        edge_c[k][2], edge_c[k][3], px, py)) begin
            dsq = (px - sx) * (px - sx) + (py - sy) * (py - sy);
            if (!r.hit || dsq < best) begin
              best = dsq;
              r.hit_x = px[COORD_BITS-1:0];
              r.hit_y = py[COORD_BITS-1:0];
            end
            r.hit = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // driver: a transfer retires the front query, then the next one may be offered
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) result_q = {result_q, predict_hit(in_data)};
      if (query_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= query_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here so the pipeline backs up into in_stall
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYC;
      hold_ack  <= hold_req;
    end
  end

  // monitor: compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    srx_out_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t unexpected result: actual %h", $time, out_data);
          err_cnt++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_data.hit !== exp_r.hit) begin
            $display("%0t hit mismatch: expected %b actual %b",
                     $time, exp_r.hit, out_data.hit);
            err_cnt++;
          end
          if (out_data.whole_inside !== exp_r.whole_inside) begin
            $display("%0t whole_inside mismatch: expected %b actual %b",
                     $time, exp_r.whole_inside, out_data.whole_inside);
            err_cnt++;
          end
          if (out_data.hit_x !== exp_r.hit_x) begin
            $display("%0t hit_x mismatch: expected %h actual %h",
                     $time, exp_r.hit_x, out_data.hit_x);
            err_cnt++;
          end
          if (out_data.hit_y !== exp_r.hit_y) begin
            $display("%0t hit_y mismatch: expected %h actual %h",
                     $time, exp_r.hit_y, out_data.hit_y);
            err_cnt++;
          end
        end
      end
      out_stall <= (hold_left > 1) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > MAX_CYC) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic add_query(input logic op, input logic signed [31:0] sx, sy, ex, ey,
                           ax, ay, bx, by);
    srx_in_t q;
    q = '{op, sx, sy, ex, ey, ax, ay, bx, by};
    query_q = {query_q, q};
  endtask

  // coordinate mix: mostly near the origin so crossings are common, some full range
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2, 3, 4: return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
      default: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_size();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return -$signed($urandom_range(32'h0008_0000));
      default: return $signed($urandom_range(32'h0010_0000));
    endcase
  endfunction

  task automatic add_random();
    logic signed [31:0] x, y, w, h;
    case ($urandom_range(9))
      0, 1, 2, 3:
        add_query(OP_SEGMENT, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord());
      4, 5, 6, 7:
        add_query(OP_RECT, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_size(), rand_size());
      8: begin
        // segment fully inside the rectangle
        x = rand_coord();  y = rand_coord();
        w = $urandom_range(32'h0010_0000);  h = $urandom_range(32'h0010_0000);
        add_query(OP_RECT, x + $urandom_range(w), y + $urandom_range(h),
                  x + $urandom_range(w), y + $urandom_range(h), x, y, w, h);
      end
      default: begin
        // parallel segments offset by ONE in x, or two segments from a shared start
        x = rand_coord();  y = rand_coord();  w = rand_coord();  h = rand_coord();
        add_query(OP_SEGMENT, x, y, x + w, y + h, x + ($urandom_range(1) ? ONE : 0),
                  y, x + ONE + w, y + h);
      end
    endcase
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: plain crossings, endpoints touching, parallel, collinear overlap, zero length
    add_query(OP_SEGMENT, 0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0);
    add_query(OP_SEGMENT, 0, 0, 3*ONE, ONE, 0, ONE, ONE, 0);
    add_query(OP_SEGMENT, 0, 0, ONE, 0, ONE, 0, ONE, ONE);
    add_query(OP_SEGMENT, 0, 0, ONE, ONE, 0, ONE, ONE, 2*ONE);
    add_query(OP_SEGMENT, 0, 0, 2*ONE, 0, ONE, 0, 3*ONE, 0);
    add_query(OP_SEGMENT, 0, 0, 0, 0, 0, 0, ONE, ONE);
    // field extremes
    add_query(OP_SEGMENT, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_query(OP_RECT, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
    add_query(OP_RECT, 32'h8000_0000, 0, 32'h7fff_ffff, 0,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_query(OP_RECT, '1, '1, '1, '1, '1, '1, '1, '1);
    // rectangle: whole inside, inside on the edges, crossing, through a corner
    add_query(OP_RECT, ONE, ONE, 2*ONE, 2*ONE, 0, 0, 4*ONE, 4*ONE);
    add_query(OP_RECT, 0, 0, 4*ONE, 4*ONE, 0, 0, 4*ONE, 4*ONE);
    add_query(OP_RECT, -ONE, 2*ONE, 5*ONE, 2*ONE, 0, 0, 4*ONE, 4*ONE);
    add_query(OP_RECT, 2*ONE, 2*ONE, 6*ONE, 3*ONE, 0, 0, 4*ONE, 4*ONE);
    add_query(OP_RECT, -ONE, -ONE, 5*ONE, 5*ONE, 0, 0, 4*ONE, 4*ONE);
    // negative size: nothing inside, edges still crossed; last, a plain miss
    add_query(OP_RECT, ONE, ONE, ONE, ONE, 2*ONE, 2*ONE, -2*ONE, -2*ONE);
    add_query(OP_RECT, 0, -ONE, ONE, 5*ONE, 2*ONE, 0, -3*ONE, 4*ONE);
    add_query(OP_RECT, 5*ONE, 5*ONE, 6*ONE, 6*ONE, 0, 0, ONE, ONE);

    // random phases: long receiver hold-off, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      wait (query_q.size() == 0);
      @(negedge clk);
      send_idle_pct  = (ph == 1) ? 66 : (ph == 3) ? 36 : 0;
      recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 36 : 0;
      if (ph == 0) hold_req = ~hold_req;
      for (int i = 0; i < 100; i++) add_random();
    end

    wait (query_q.size() == 0 && !in_valid);
    wait (result_q.size() == 0);
    repeat (LATENCY + 10) @(negedge clk);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
